>>> src/ihb_pkg.sv
// ----------------------------------------------------------------------------
// ihb_pkg: shared types and constants for the IPv4 header builder
// Item layouts for both channels, the queue entry and the fixed header words.
// ----------------------------------------------------------------------------
package ihb_pkg;

  localparam int HDR_WORDS = 10;
  localparam int SUM_W     = 19;  // six 16-bit terms plus a constant stay below 2^19

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [7:0]  upper_protocol;
    logic [15:0] payload_len;
  } ihb_in_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;
    logic [31:0] next_hop;
    logic        off_subnet;
  } ihb_out_t;

  typedef struct packed {
    logic [31:0]      dest_addr;
    logic [7:0]       upper_protocol;
    logic [15:0]      total_len;
    logic [SUM_W-1:0] raw_sum;
    logic [31:0]      next_hop;
    logic             off_subnet;
  } ihb_entry_t;

  // fixed header words
  localparam logic [15:0] W_VER_IHL = 16'h4500;
  localparam logic [15:0] W_IDENT   = 16'h0001;
  localparam logic [15:0] W_FLAGS   = 16'h4000;
  localparam logic [7:0]  TTL       = 8'h40;
  localparam logic [15:0] HDR_BYTES = 16'd20;
  // sum of the constant words: 0x4500 + 0x0001 + 0x4000 + 0x4000 (TTL byte)
  localparam logic [15:0] CONST_SUM = 16'hC501;

  // word positions
  localparam logic [3:0] IDX_VER   = 4'd0;
  localparam logic [3:0] IDX_LEN   = 4'd1;
  localparam logic [3:0] IDX_ID    = 4'd2;
  localparam logic [3:0] IDX_FLAGS = 4'd3;
  localparam logic [3:0] IDX_TTL   = 4'd4;
  localparam logic [3:0] IDX_CSUM  = 4'd5;
  localparam logic [3:0] IDX_SRC_H = 4'd6;
  localparam logic [3:0] IDX_SRC_L = 4'd7;
  localparam logic [3:0] IDX_DST_H = 4'd8;
  localparam logic [3:0] IDX_DST_L = 4'd9;
  localparam logic [3:0] IDX_LAST  = 4'd9;

  // register indexes
  localparam logic [1:0] REG_LOCAL_IP = 2'd0;
  localparam logic [1:0] REG_MASK     = 2'd1;
  localparam logic [1:0] REG_GATEWAY  = 2'd2;

endpackage

>>> src/ihb_front.sv
// ----------------------------------------------------------------------------
// ihb_front: request intake
// Takes a request, classifies the destination against the subnet, works out
// total length and the raw header sum, and holds the result for the queue.
// ----------------------------------------------------------------------------
module ihb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         local_ip,
  input  logic [31:0]         subnet_mask,
  input  logic [31:0]         gateway_ip,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihb_pkg::ihb_in_t    in_data,
  output logic                push,
  input  logic                push_ready,
  output ihb_pkg::ihb_entry_t push_data
);
  import ihb_pkg::*;

  logic       fv_r, fv_nxt;
  ihb_entry_t fe_r, fe_nxt;
  logic       in_acc;
  logic       off;
  logic [15:0] tot_len;

  assign push      = fv_r;
  assign push_data = fe_r;
  assign in_ready  = !fv_r || push_ready;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    off     = ((in_data.dest_addr ^ local_ip) & subnet_mask) != 32'd0;
    tot_len = in_data.payload_len + HDR_BYTES;  // wraps modulo 2^16
    fe_nxt.dest_addr      = in_data.dest_addr;
    fe_nxt.upper_protocol = in_data.upper_protocol;
    fe_nxt.total_len      = tot_len;
    fe_nxt.next_hop       = off ? gateway_ip : in_data.dest_addr;
    fe_nxt.off_subnet     = off;
    fe_nxt.raw_sum = SUM_W'(CONST_SUM) + SUM_W'(tot_len)
                   + SUM_W'(in_data.upper_protocol)
                   + SUM_W'(local_ip[31:16]) + SUM_W'(local_ip[15:0])
                   + SUM_W'(in_data.dest_addr[31:16]) + SUM_W'(in_data.dest_addr[15:0]);
  end

  always_comb begin
    fv_nxt = fv_r;
    if (in_acc) begin
      fv_nxt = 1'b1;
    end else if (push && push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fe_r <= fe_nxt;
    end
  end

endmodule

>>> src/ihb_queue.sv
// ----------------------------------------------------------------------------
// ihb_queue: request queue
// Small FIFO of classified requests between intake and the word sequencer.
// ----------------------------------------------------------------------------
module ihb_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                push_ready,
  input  ihb_pkg::ihb_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output ihb_pkg::ihb_entry_t pop_data
);
  import ihb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ihb_entry_t        mem [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_data;
    end
  end

endmodule

>>> src/ihb_back.sv
// ----------------------------------------------------------------------------
// ihb_back: header word sequencer
// Folds the sum to the checksum; ten words go out one a cycle unless stalled.
// ----------------------------------------------------------------------------
module ihb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         local_ip,
  input  logic                pop_valid,
  output logic                pop,
  input  ihb_pkg::ihb_entry_t pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ihb_pkg::ihb_out_t   out_data
);
  import ihb_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  ihb_entry_t  cur_r;
  logic [15:0] csum_r, csum_nxt;
  logic        out_acc, done, ld;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] word;

  assign out_acc = out_valid && out_ready;
  assign done    = out_acc && (idx_r == IDX_LAST);
  assign ld      = pop_valid && (!busy_r || done);
  assign pop     = ld;

  // two end-around carry folds bring the 19-bit sum to 16 bits
  always_comb begin
    fold1    = 17'(pop_data.raw_sum[15:0]) + 17'(pop_data.raw_sum[SUM_W-1:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    csum_nxt = ~fold2;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (ld) begin
      busy_nxt = 1'b1;
      idx_nxt  = IDX_VER;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_acc) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= IDX_VER;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cur_r  <= pop_data;
      csum_r <= csum_nxt;
    end
  end

  always_comb begin
    case (idx_r)
      IDX_VER:   word = W_VER_IHL;
      IDX_LEN:   word = cur_r.total_len;
      IDX_ID:    word = W_IDENT;
      IDX_FLAGS: word = W_FLAGS;
      IDX_TTL:   word = {TTL, cur_r.upper_protocol};
      IDX_CSUM:  word = csum_r;
      IDX_SRC_H: word = local_ip[31:16];
      IDX_SRC_L: word = local_ip[15:0];
      IDX_DST_H: word = cur_r.dest_addr[31:16];
      IDX_DST_L: word = cur_r.dest_addr[15:0];
      default:   word = W_VER_IHL;
    endcase
  end

  assign out_valid            = busy_r;
  assign out_data.header_word = word;
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = idx_r == IDX_LAST;
  assign out_data.next_hop    = cur_r.next_hop;
  assign out_data.off_subnet  = cur_r.off_subnet;

endmodule

>>> src/ipv4_header_builder.sv
// ----------------------------------------------------------------------------
// ipv4_header_builder: IPv4 header generator with header checksum
// Builds the 20-byte IPv4 header for each request and sends it as ten words.
// ----------------------------------------------------------------------------
// Each accepted request yields ten 16-bit header words in network order, one
// per cycle while out_ready is high; that pace is set by the word sequencer.
// Intake computes the subnet decision, total length and header sum in the
// cycle a request is taken and parks it in a small queue (QUEUE_DEPTH
// entries plus one intake register), so new requests are taken while earlier
// headers are still going out, and consecutive headers leave with no gap.
// Registers local_ip, subnet_mask and gateway_ip sit at byte addresses 0, 4
// and 8 and are meant to be written only while the block is idle.
module ipv4_header_builder #(
  parameter int QUEUE_DEPTH = 2  // 2 or more
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihb_pkg::ihb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ihb_pkg::ihb_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import ihb_pkg::*;

  logic [31:0] local_ip_r, mask_r, gw_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        q_push, q_push_ready, q_pop, q_valid;
  ihb_entry_t  q_in, q_out;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      mask_r     <= '0;
      gw_r       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOCAL_IP: local_ip_r <= cfg_pwdata;
        REG_MASK:     mask_r     <= cfg_pwdata;
        REG_GATEWAY:  gw_r       <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LOCAL_IP: cfg_prdata = local_ip_r;
      REG_MASK:     cfg_prdata = mask_r;
      REG_GATEWAY:  cfg_prdata = gw_r;
      default:      cfg_prdata = '0;
    endcase
  end

  ihb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .local_ip    (local_ip_r),
    .subnet_mask (mask_r),
    .gateway_ip  (gw_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push        (q_push),
    .push_ready  (q_push_ready),
    .push_data   (q_in)
  );

  ihb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  ihb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .local_ip  (local_ip_r),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a header, once started, runs through its words in order
  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 4'd1))
    else $error("header word skipped or dropped");

  // a new header starts at word 0
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_data.word_index == IDX_VER))
    else $error("header did not start at first word");

  // output falls idle after the last word only when nothing is queued
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |-> (q_pop == q_valid))
    else $error("queued item not picked up after last word");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the IPv4 header builder
// Requests go in through a streaming or bursty valid/ready driver and the ten
// header words of each come back through a monitor with its own stall pattern.
// Each taken request is turned into ten expected words by a local header
// calculator (checksum fold, subnet test, next hop); the monitor checks each word.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import ihb_pkg::*;

  // header contents as the protocol defines them
  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [15:0] IDENT_WORD   = 16'h0001;
  localparam logic [15:0] DF_WORD      = 16'h4000;
  localparam logic [7:0]  TTL_BYTE     = 8'h40;
  localparam logic [15:0] HDR_LEN      = 16'd20;
  localparam logic [15:0] MAX_PAYLOAD  = 16'd65515;

  // index 3 has no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 76;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN, SINK_SLOW} sink_mode_t;
  typedef enum logic {SRC_STREAM, SRC_BURSTY} src_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ihb_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ihb_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // local copy of the registers
  logic [31:0] src_ip = '0;
  logic [31:0] net_mask = '0;
  logic [31:0] gw_ip = '0;

  ihb_in_t  pending_reqs[$];
  ihb_out_t words_due[$];
  ihb_out_t want_word;

  int         reqs_queued = 0;
  int         reqs_taken = 0;
  int         errors = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_requests = 0;
  int         holds_taken = 0;
  int         hold_left = 0;
  logic [7:0] stall_pattern = 8'b1101_1001;
  sink_mode_t sink_mode = SINK_ALWAYS;
  src_mode_t  src_mode = SRC_STREAM;

  ipv4_header_builder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) $display("error at cycle %0d: %s", cycle_count, msg);
  endtask

  // ten expected words for one request under the current register values
  function automatic void build_header(input ihb_in_t req);
    logic [15:0] words [HDR_WORDS];
    logic [31:0] acc;
    logic        off;
    logic [31:0] hop;
    ihb_out_t    w;
    int          k;
    words[0] = VER_IHL_WORD;
    words[1] = req.payload_len + HDR_LEN;  // wraps past 65535 on purpose
    words[2] = IDENT_WORD;
    words[3] = DF_WORD;
    words[4] = {TTL_BYTE, req.upper_protocol};
    words[5] = '0;
    words[6] = src_ip[31:16];
    words[7] = src_ip[15:0];
    words[8] = req.dest_addr[31:16];
    words[9] = req.dest_addr[15:0];
    acc = '0;
    for (k = 0; k < HDR_WORDS; k++) acc += 32'(words[k]);
    while (acc[31:16] != 0) acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    words[5] = ~acc[15:0];
    off = |((req.dest_addr ^ src_ip) & net_mask);
    hop = off ? gw_ip : req.dest_addr;
    for (k = 0; k < HDR_WORDS; k++) begin
      w.header_word = words[k];
      w.word_index  = 4'(k);
      w.last_word   = (k == HDR_WORDS - 1);
      w.next_hop    = hop;
      w.off_subnet  = off;
      words_due.push_back(w);
    end
  endfunction

  // sender: bursty mode gives random bursts, with gaps only once an item has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_header(in_data);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (src_mode == SRC_BURSTY) begin
            if (burst_left == 0) begin
              burst_left <= $urandom_range(0, 11);
              gap_left   <= $urandom_range(1, 8);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: out_ready <= 1'b1;
        SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: begin
          out_ready     <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
        end
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        report_error($sformatf("word %h at index %0d with nothing outstanding",
                               out_data.header_word, out_data.word_index));
      end else begin
        want_word = words_due.pop_front();
        if (out_data.header_word !== want_word.header_word)
          report_error($sformatf("header_word %h, expected %h (index %0d)",
                                 out_data.header_word, want_word.header_word,
                                 want_word.word_index));
        if (out_data.word_index !== want_word.word_index)
          report_error($sformatf("word_index %0d, expected %0d",
                                 out_data.word_index, want_word.word_index));
        if (out_data.last_word !== want_word.last_word)
          report_error($sformatf("last_word %b, expected %b (index %0d)",
                                 out_data.last_word, want_word.last_word,
                                 want_word.word_index));
        if (out_data.next_hop !== want_word.next_hop)
          report_error($sformatf("next_hop %h, expected %h", out_data.next_hop,
                                 want_word.next_hop));
        if (out_data.off_subnet !== want_word.off_subnet)
          report_error($sformatf("off_subnet %b, expected %b", out_data.off_subnet,
                                 want_word.off_subnet));
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd_want;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);  // register takes the value on this edge
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LOCAL_IP: begin
        src_ip  = value;
        rd_want = value;
      end
      REG_MASK: begin
        net_mask = value;
        rd_want  = value;
      end
      REG_GATEWAY: begin
        gw_ip   = value;
        rd_want = value;
      end
      default: rd_want = '0;
    endcase
    // address still points at the register, so read it back
    @(negedge clk);
    if (cfg_pready !== 1'b1)
      report_error("cfg_pready low");
    if (cfg_prdata !== rd_want)
      report_error($sformatf("register %0d reads %h, expected %h", idx, cfg_prdata,
                             rd_want));
  endtask

  task automatic set_registers(input logic [31:0] ip, input logic [31:0] mask,
                               input logic [31:0] gw);
    write_reg(REG_LOCAL_IP, ip);
    write_reg(REG_MASK, mask);
    write_reg(REG_GATEWAY, gw);
    // junk to the unused slot must change nothing
    write_reg(REG_SPARE, $urandom());
  endtask

  task automatic queue_req(input logic [31:0] dest, input logic [7:0] proto,
                           input logic [15:0] plen);
    ihb_in_t req;
    req.dest_addr      = dest;
    req.upper_protocol = proto;
    req.payload_len    = plen;
    pending_reqs.push_back(req);
    reqs_queued++;
  endtask

  task automatic queue_random_req();
    logic [31:0] dest;
    logic [15:0] plen;
    case ($urandom_range(0, 5))
      0, 1, 2: dest = (src_ip & net_mask) | ($urandom() & ~net_mask);
      3:       dest = src_ip ^ (32'h1 << $urandom_range(0, 31));
      4:       dest = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: dest = $urandom();
    endcase
    case ($urandom_range(0, 9))
      0:       plen = '0;
      1:       plen = MAX_PAYLOAD;
      2:       plen = 16'($urandom_range(int'(MAX_PAYLOAD) + 1, 65535));
      default: plen = 16'($urandom_range(0, int'(MAX_PAYLOAD)));
    endcase
    queue_req(dest, 8'($urandom_range(0, 255)), plen);
  endtask

  // wait for every item to be taken and every word to come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((reqs_taken != reqs_queued || words_due.size() != 0) && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (words_due.size() != 0 || reqs_taken != reqs_queued)
      report_error($sformatf("%0d words still outstanding, %0d items not taken",
                             words_due.size(), reqs_queued - reqs_taken));
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input bit as_mask);
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return as_mask ? (32'hFFFF_FFFF << $urandom_range(1, 31)) : $urandom();
      default: return $urandom();
    endcase
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    int p;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: zero mask, every destination is local
    queue_req(32'h0000_0000, 8'h00, 16'd0);
    queue_req(32'hFFFF_FFFF, 8'hFF, MAX_PAYLOAD);
    queue_req(32'h0A00_0001, 8'h06, MAX_PAYLOAD + 16'd1);  // total length wraps to zero
    queue_req(32'h8000_0000, 8'h11, 16'hFFFF);
    queue_req(32'h0000_3AEA, 8'h00, 16'd0);  // sum folds to all ones, checksum zero
    queue_req(32'h5555_AAAA, 8'h01, 16'h5555);
    queue_req(32'hAAAA_5555, 8'h80, 16'hAAAA);
    wait_idle();

    set_registers(32'hC0A8_0001, 32'hFFFF_FF00, 32'hC0A8_00FE);
    queue_req(32'hC0A8_0042, 8'h06, 16'd100);
    queue_req(32'h0808_0808, 8'h11, 16'd512);
    queue_req(32'hC0A8_0001, 8'h01, 16'd0);
    queue_req(32'hC0A8_0101, 8'h06, 16'd20);  // one bit under the mask differs
    queue_req(32'hC0A8_00FF, 8'h11, 16'd1);
    queue_req(32'hFFFF_FFFF, 8'hFF, MAX_PAYLOAD);
    queue_req(32'h0000_0000, 8'h00, 16'hFFEC);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
          src_mode  = SRC_STREAM;
          sink_mode = SINK_ALWAYS;
        end
        1: begin
          set_registers(pick_value(1'b0), pick_value(1'b1), pick_value(1'b0));
          src_mode  = SRC_STREAM;
          sink_mode = SINK_RANDOM;
        end
        2: begin
          set_registers(32'h0, 32'h0, 32'hFFFF_FFFF);
          src_mode  = SRC_BURSTY;
          sink_mode = SINK_PATTERN;
        end
        default: begin
          set_registers(pick_value(1'b0), pick_value(1'b1), pick_value(1'b0));
          src_mode  = src_mode_t'($urandom_range(0, 1));
          sink_mode = sink_mode_t'($urandom_range(0, 3));
        end
      endcase
      if (p == 2) begin
        // sender stops halfway until the output has fully drained
        for (n = 0; n < PHASE_ITEMS / 2; n++) queue_random_req();
        wait_idle();
        for (n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++) queue_random_req();
      end else begin
        for (n = 0; n < PHASE_ITEMS; n++) queue_random_req();
        if (p == 1) hold_requests++;  // output blocked, input keeps pushing
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ihb_pkg.sv
src/ihb_front.sv
src/ihb_queue.sv
src/ihb_back.sv
src/ipv4_header_builder.sv
test/tb_top.sv
